### design/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types, mode codes, register indexes and cadence helper functions
// for the pulldown cadence detector.
// ----------------------------------------------------------------------------
package pcd_pkg;

	// switch history ring
	localparam int HIST_DEPTH = 64;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

	localparam int CYCLE_LEN  = 5;

	// mode codes
	localparam logic [2:0] MODE_VIDEO = 3'd0;
	localparam logic [2:0] MODE_FILM0 = 3'd1;
	localparam logic [2:0] MODE_FILM4 = 3'd5;
	localparam logic [2:0] MODE_COMB  = 3'd6;
	localparam logic [2:0] CODE_NONE  = 3'd7;

	// configuration register indexes
	localparam logic [2:0] CFG_DIFF_THR     = 3'd0;
	localparam logic [2:0] CFG_MISMATCH_THR = 3'd1;
	localparam logic [2:0] CFG_COMB_THR     = 3'd2;
	localparam logic [2:0] CFG_FALLBACK     = 3'd3;
	localparam logic [2:0] CFG_REPEAT_IN    = 3'd4;
	localparam logic [2:0] CFG_REPEAT_OUT   = 3'd5;
	localparam logic [2:0] CFG_SWITCH_MAX   = 3'd6;
	localparam logic [2:0] CFG_SWITCH_IVL   = 3'd7;

	localparam int CFG_DW = 14;

	typedef struct packed {
		logic [12:0] diff_threshold;
		logic [13:0] mismatch_threshold;
		logic [12:0] comb_threshold;
		logic        fallback_to_video;
		logic [3:0]  repeat_in;
		logic [3:0]  repeat_out;
		logic [6:0]  switch_max;
		logic [13:0] switch_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [23:0] field_diff;
		logic [23:0] comb_factor;
		logic        is_odd;
		logic [2:0]  cadence_pos;
		logic [31:0] time_ms;
		logic        restart;
	} item_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       fell_to_video;
		logic       entered_comb;
		logic       rapid_cycling;
		logic       expect_weave;
	} result_t;

	// decision -> switch history
	typedef struct packed {
		logic        clear;
		logic        push;
		logic [2:0]  mode;
		logic [31:0] stamp;
	} hist_ctl_t;

	// switch history -> decision
	typedef struct packed {
		logic [2:0] mode0;
		logic       rapid;
	} hist_sts_t;

	function automatic logic is_film(input logic [2:0] m);
		return (m >= MODE_FILM0) && (m <= MODE_COMB);
	endfunction

	// weave expectation of a locked film phase at a cadence position
	function automatic logic expect_weave_of(input logic [2:0] m, input logic [2:0] pos,
	                                         input logic odd);
		logic [3:0] t;
		logic [3:0] r;
		logic       w;
		t = 4'({1'b0, pos}) + 4'(CYCLE_LEN) - 4'({1'b0, m - MODE_FILM0});
		r = (t >= 4'(CYCLE_LEN)) ? t - 4'(CYCLE_LEN) : t;
		if (m < MODE_FILM0 || m > MODE_FILM4 || pos >= 3'(CYCLE_LEN)) begin
			w = 1'b0;
		end else if (r == 4'd0) begin
			w = 1'b0;
		end else if (r <= 4'd2) begin
			w = ~odd;
		end else begin
			w = odd;
		end
		return w;
	endfunction

	// film phase implied by a match at this cadence position
	function automatic logic [2:0] mode_from_pos(input logic [2:0] pos, input logic odd);
		logic [3:0] t;
		logic [3:0] r;
		t = 4'({1'b0, pos}) + (odd ? 4'd2 : 4'd4);
		r = (t >= 4'(CYCLE_LEN)) ? t - 4'(CYCLE_LEN) : t;
		if (pos >= 3'(CYCLE_LEN)) begin
			return MODE_FILM0;
		end
		return r[2:0] + MODE_FILM0;
	endfunction

endpackage

### design/pcd_ram.sv
// ----------------------------------------------------------------------------
// pcd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/pcd_history.sv
// ----------------------------------------------------------------------------
// pcd_history
// Film mode switch log: timestamp ring in RAM, fill count, newest mode and
// the rapid cycling window check.
// ----------------------------------------------------------------------------
module pcd_history
	import pcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  hist_ctl_t   ctl,
	input  logic [6:0]  switch_max,
	input  logic [6:0]  switch_max_next,
	input  logic [13:0] switch_interval_ms,
	output hist_sts_t   sts
);

	logic [HIST_AW-1:0] wp_q;
	logic [HIST_AW-1:0] wp_next;
	logic [HIST_CW-1:0] count_q;
	logic [HIST_CW-1:0] count_after;
	logic [2:0]         mode0_q;
	logic [HIST_AW-1:0] k;
	logic [HIST_AW:0]   raddr_w;
	logic [HIST_AW-1:0] raddr;
	logic [31:0]        ram_rdata;
	logic               hit_q;
	logic [31:0]        stamp_q;
	logic [31:0]        old_time;
	logic [31:0]        age;

	always_comb begin
		if (ctl.push) begin
			wp_next = (wp_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		end else begin
			wp_next = wp_q;
		end
	end

	// the next push lands at wp_next, so entry switch_max-1 after it lives
	// switch_max-1 slots behind wp_next
	always_comb begin
		if (switch_max_next >= 7'd2 && 8'(switch_max_next) <= 8'(HIST_DEPTH)) begin
			k = HIST_AW'(switch_max_next - 7'd1);
		end else begin
			k = '0;
		end
		if (wp_next >= k) begin
			raddr_w = {1'b0, wp_next} - {1'b0, k};
		end else begin
			raddr_w = {1'b0, wp_next} + (HIST_AW + 1)'(HIST_DEPTH) - {1'b0, k};
		end
		raddr = raddr_w[HIST_AW-1:0];
	end

	pcd_ram #(
		.WIDTH(32),
		.DEPTH(HIST_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.push),
		.waddr(wp_q),
		.wdata(ctl.stamp),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// forward a timestamp written in the same cycle it is read
	always_ff @(posedge clk) begin
		hit_q   <= ctl.push && (raddr == wp_q);
		stamp_q <= ctl.stamp;
	end

	assign old_time = hit_q ? stamp_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			count_q <= '0;
			mode0_q <= MODE_VIDEO;
		end else begin
			wp_q <= wp_next;
			if (ctl.clear) begin
				count_q <= '0;
				mode0_q <= MODE_VIDEO;
			end else if (ctl.push) begin
				count_q <= count_after;
				mode0_q <= ctl.mode;
			end
		end
	end

	// window check as if the stamp were pushed now
	always_comb begin
		count_after = (count_q < HIST_CW'(HIST_DEPTH)) ? count_q + 1'b1 : count_q;
		age         = ctl.stamp - old_time;
		sts.mode0   = mode0_q;
		sts.rapid   = (switch_max > 7'd1) && (switch_interval_ms != '0) &&
		              (8'(switch_max) <= 8'(count_after)) &&
		              (8'(switch_max) <= 8'(HIST_DEPTH)) &&
		              (old_time != '0) && (age <= 32'(switch_interval_ms));
	end

endmodule

### design/pcd_decide.sv
// ----------------------------------------------------------------------------
// pcd_decide
// Cadence state registers and the per-field mode decision.
// ----------------------------------------------------------------------------
module pcd_decide
	import pcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  item_t     item,
	input  cfg_t      cfg,
	input  hist_sts_t hsts,
	output hist_ctl_t hctl,
	output result_t   res
);

	logic [2:0]  mode_q, mode_n;
	logic [7:0]  mc_q, mc_n;
	logic [4:0]  vc_q, vc_n;
	logic [4:0]  tr_q, tr_n;
	logic [2:0]  lfp_q, lfp_n;
	logic [23:0] lc_q, lc_n;
	logic [2:0]  llm_q, llm_n;

	always_comb begin
		logic [3:0] rsel;
		logic [6:0] lim;
		logic [2:0] nf;
		logic [4:0] need;
		logic       weave;
		logic       artifact;
		logic       push;

		mode_n = mode_q;
		mc_n   = mc_q;
		vc_n   = vc_q;
		tr_n   = tr_q;
		lfp_n  = lfp_q;
		lc_n   = lc_q;
		llm_n  = llm_q;
		res    = '0;
		push   = 1'b0;
		weave  = 1'b0;
		rsel   = cfg.fallback_to_video ? cfg.repeat_out : cfg.repeat_in;
		lim    = {1'b0, rsel, 2'b00} + {3'b000, rsel};
		nf     = mode_from_pos(item.cadence_pos, item.is_odd);
		need   = (tr_q != '0) ? tr_q : {1'b0, cfg.repeat_in};
		artifact = (cfg.mismatch_threshold != '0) &&
		           (item.field_diff >= 24'(cfg.mismatch_threshold)) &&
		           ({1'b0, item.comb_factor} > {1'b0, lc_q} + 25'(cfg.comb_threshold)) &&
		           (item.comb_factor > 24'(cfg.comb_threshold));

		if (item.restart) begin
			mc_n  = '0;
			vc_n  = '0;
			lfp_n = CODE_NONE;
			lc_n  = '0;
		end else begin
			weave = expect_weave_of(mode_q, item.cadence_pos, item.is_odd);
			if (item.field_diff > 24'(cfg.diff_threshold)) begin
				if (is_film(mode_q)) begin
					if (mc_q > {1'b0, lim}) begin
						mode_n = MODE_VIDEO;
						res.fell_to_video = 1'b1;
						vc_n = '0;
					end else begin
						if (artifact && weave) begin
							if (cfg.fallback_to_video) begin
								mode_n = MODE_VIDEO;
								res.fell_to_video = 1'b1;
								tr_n = 5'd1;
								vc_n = '0;
							end else begin
								mode_n = MODE_COMB;
								res.entered_comb = 1'b1;
								vc_n  = {1'b0, cfg.repeat_in};
								tr_n  = '0;
								lfp_n = MODE_COMB;
							end
						end
						if (mc_q != 8'hFF) mc_n = mc_q + 1'b1;
					end
				end else if (mc_q != 8'hFF) begin
					mc_n = mc_q + 1'b1;
				end
			end else begin
				if (mc_q == 8'd4) begin
					if (nf == lfp_q || (is_film(mode_q) && lfp_q == MODE_COMB) ||
					    lfp_q == CODE_NONE) begin
						if (vc_q >= need) begin
							tr_n   = '0;
							mode_n = nf;
							if (llm_q != nf && nf != hsts.mode0) begin
								push = 1'b1;
								if (hsts.rapid) begin
									res.rapid_cycling = 1'b1;
									if (cfg.fallback_to_video) begin
										mode_n = MODE_VIDEO;
										res.fell_to_video = 1'b1;
										vc_n = '0;
										tr_n = {cfg.repeat_in, 1'b0};
									end
								end
							end
							llm_n = mode_n;
						end else if (vc_q != 5'd31) begin
							vc_n = vc_q + 1'b1;
						end
						lfp_n = nf;
					end else if (cfg.fallback_to_video && !is_film(mode_q)) begin
						vc_n  = 5'd1;
						lfp_n = nf;
					end else begin
						mode_n = nf;
						if (nf != hsts.mode0) begin
							push = 1'b1;
							if (hsts.rapid) begin
								res.rapid_cycling = 1'b1;
								mode_n = MODE_VIDEO;
								res.fell_to_video = 1'b1;
								vc_n = '0;
								tr_n = {cfg.repeat_in, 1'b0};
							end
						end
						if (!cfg.fallback_to_video) lfp_n = nf;
					end
				end else if (tr_q != '0) begin
					vc_n = '0;
				end
				mc_n = '0;
			end
			if (item.comb_factor != '0) lc_n = item.comb_factor;
		end

		res.mode         = mode_n;
		res.expect_weave = weave;
		hctl.clear = adv && item.restart;
		hctl.push  = adv && push;
		hctl.mode  = nf;
		hctl.stamp = item.time_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_VIDEO;
			mc_q   <= '0;
			vc_q   <= '0;
			tr_q   <= '0;
			lfp_q  <= CODE_NONE;
			lc_q   <= '0;
			llm_q  <= CODE_NONE;
		end else if (adv) begin
			mode_q <= mode_n;
			mc_q   <= mc_n;
			vc_q   <= vc_n;
			tr_q   <= tr_n;
			lfp_q  <= lfp_n;
			lc_q   <= lc_n;
			llm_q  <= llm_n;
		end
	end

endmodule

### design/pulldown_cadence_detector_top.sv
// ----------------------------------------------------------------------------
// pulldown_cadence_detector_top
// 3:2 pulldown cadence detector: one mode decision per video field request.
// ----------------------------------------------------------------------------
// Each input request carries one field's metrics and yields exactly one result
// request with the chosen mode (video, one of five film phases, or comb) and
// the event flags. A new field is taken every cycle while the result side
// keeps up. The input register feeds one level of decision logic and the
// result lands in an output register. While a result waits for the consumer,
// the input register still takes one more field; with both registers full,
// s_axis_tready follows m_axis_tready. Film mode switches are logged in a
// 64-entry timestamp ring held in RAM; its registered read port is addressed
// ahead from the next write pointer and the pending switch_max value, so the
// rapid cycling window check still resolves in the same cycle as its field.
// A restart request empties the log by clearing its fill count, with no
// clearing pass. Configuration writes take effect at the edge they are issued
// and belong to idle periods only.
// ----------------------------------------------------------------------------
module pulldown_cadence_detector_top
	import pcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input field metrics
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// [23:0] field_diff, [47:24] comb_factor, [48] is_odd, [51:49] cadence_pos,
	// [83:52] time_ms, [87:84] zero
	input  logic [87:0]       s_axis_tdata,
	// [0] restart
	input  logic              s_axis_tuser,
	// decision results
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [2:0] mode, [3] fell_to_video, [4] entered_comb, [5] rapid_cycling,
	// [6] expect_weave, [7] zero
	output logic [7:0]        m_axis_tdata,
	// configuration write port
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic [6:0] switch_max_next;
	item_t     item_s1;
	logic      valid_s1;
	logic      adv;
	logic      in_acc;
	result_t   res;
	result_t   res_q;
	logic      out_valid_q;
	hist_ctl_t hctl;
	hist_sts_t hsts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_threshold     <= 13'd15;
			cfg_q.mismatch_threshold <= 14'd100;
			cfg_q.comb_threshold     <= 13'd300;
			cfg_q.fallback_to_video  <= 1'b1;
			cfg_q.repeat_in          <= 4'd4;
			cfg_q.repeat_out         <= 4'd2;
			cfg_q.switch_max         <= 7'd4;
			cfg_q.switch_interval_ms <= 14'd3000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIFF_THR:     cfg_q.diff_threshold     <= cfg_data[12:0];
				CFG_MISMATCH_THR: cfg_q.mismatch_threshold <= cfg_data[13:0];
				CFG_COMB_THR:     cfg_q.comb_threshold     <= cfg_data[12:0];
				CFG_FALLBACK:     cfg_q.fallback_to_video  <= cfg_data[0];
				CFG_REPEAT_IN:    cfg_q.repeat_in          <= cfg_data[3:0];
				CFG_REPEAT_OUT:   cfg_q.repeat_out         <= cfg_data[3:0];
				CFG_SWITCH_MAX:   cfg_q.switch_max         <= cfg_data[6:0];
				CFG_SWITCH_IVL:   cfg_q.switch_interval_ms <= cfg_data[13:0];
			endcase
		end
	end

	// history read address looks ahead: take a pending write into account
	assign switch_max_next = (cfg_we && cfg_index == CFG_SWITCH_MAX) ? cfg_data[6:0]
	                                                                 : cfg_q.switch_max;

	// advance the input stage when the output register is free or being drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the field payload in the input stage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.field_diff  <= s_axis_tdata[23:0];
			item_s1.comb_factor <= s_axis_tdata[47:24];
			item_s1.is_odd      <= s_axis_tdata[48];
			item_s1.cadence_pos <= s_axis_tdata[51:49];
			item_s1.time_ms     <= s_axis_tdata[83:52];
			item_s1.restart     <= s_axis_tuser;
		end
	end

	pcd_decide u_decide (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.item  (item_s1),
		.cfg   (cfg_q),
		.hsts  (hsts),
		.hctl  (hctl),
		.res   (res)
	);

	pcd_history u_history (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (hctl),
		.switch_max        (cfg_q.switch_max),
		.switch_max_next   (switch_max_next),
		.switch_interval_ms(cfg_q.switch_interval_ms),
		.sts               (hsts)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, res_q.expect_weave, res_q.rapid_cycling,
	                        res_q.entered_comb, res_q.fell_to_video, res_q.mode};

endmodule

### tb/sv/tb_pulldown_cadence_detector_top.sv
// ----------------------------------------------------------------------------
// tb_pulldown_cadence_detector_top
// Self-checking bench for the 3:2 pulldown cadence detector.
// ----------------------------------------------------------------------------
// A queue of field requests feeds a clocked stream driver. Every field that is
// accepted runs through a cycle-free model of the detector held in this module,
// and the decision it gives is queued. A clocked monitor pops the oldest
// decision for every result request and compares it field by field. Stimulus
// is a short directed block followed by random 3:2 cadence runs (four
// mismatches, one match, fixed film phase), noise, restarts and broken
// cadences, under five register settings including both extremes. Both stream
// sides idle at random, and the result side holds off once for a long stretch
// so that the detector backs up its input.
// ----------------------------------------------------------------------------
module tb_pulldown_cadence_detector_top
	import pcd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;   // no-progress cycles before giving up
	localparam int HOLD_AT     = 250;    // result count that starts the long hold
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 60;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [87:0]       s_axis_tdata  = '0;
	logic              s_axis_tuser  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;
	logic              cfg_we        = 1'b0;
	logic [2:0]        cfg_index     = CFG_DIFF_THR;
	logic [CFG_DW-1:0] cfg_data      = '0;

	pulldown_cadence_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------
	// Detector model: register shadow and decision state
	// ------------------------------------------------------------------
	cfg_t det_cfg = '{
		diff_threshold:     13'd15,
		mismatch_threshold: 14'd100,
		comb_threshold:     13'd300,
		fallback_to_video:  1'b1,
		repeat_in:          4'd4,
		repeat_out:         4'd2,
		switch_max:         7'd4,
		switch_interval_ms: 14'd3000
	};

	logic [2:0]  cur_mode    = MODE_VIDEO;
	int unsigned miss_run    = 0;     // saturates at 255
	int unsigned verify_run  = 0;     // saturates at 31
	int unsigned hold_repeat = 0;     // temporary verify target, 0 = none
	logic [2:0]  seen_phase  = CODE_NONE;
	int unsigned prev_comb   = 0;
	logic [2:0]  locked_mode = CODE_NONE;
	logic [31:0] sw_stamp [HIST_DEPTH];
	logic [2:0]  sw_mode  [HIST_DEPTH];
	int unsigned sw_fill     = 0;

	item_t   field_q[$];      // field requests waiting for the driver
	result_t decision_q[$];   // decisions waiting for their result request

	// bookkeeping
	int unsigned planned      = 0;
	int unsigned fields_taken = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count   = 0;
	int unsigned reported     = 0;
	int unsigned n_film = 0, n_fell = 0, n_comb = 0, n_rapid = 0, n_restart = 0;
	int unsigned stall_cycles = 0;
	logic [31:0] gen_stamp    = 32'd0;

	function automatic bit film_like(input logic [2:0] m);
		return (m >= MODE_FILM0) && (m <= MODE_COMB);
	endfunction

	function automatic void clear_switch_log();
		for (int i = 0; i < HIST_DEPTH; i++) begin
			sw_stamp[i] = '0;
			sw_mode[i]  = MODE_VIDEO;
		end
		sw_fill = 0;
	endfunction

	// Log a film mode change; return 1 when the window test flags rapid cycling.
	function automatic bit log_switch(input logic [31:0] stamp);
		int unsigned span;
		logic [31:0] age;
		if (!film_like(cur_mode) || cur_mode == sw_mode[0])
			return 1'b0;
		for (int i = HIST_DEPTH - 1; i > 0; i--) begin
			sw_stamp[i] = sw_stamp[i-1];
			sw_mode[i]  = sw_mode[i-1];
		end
		sw_stamp[0] = stamp;
		sw_mode[0]  = cur_mode;
		if (sw_fill < HIST_DEPTH)
			sw_fill++;
		span = det_cfg.switch_max;
		if (span > 1 && det_cfg.switch_interval_ms > 0 && span <= sw_fill &&
		    span <= HIST_DEPTH && sw_stamp[span-1] > 0) begin
			age = sw_stamp[0] - sw_stamp[span-1];
			if (age <= det_cfg.switch_interval_ms)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// One field in, one decision out; advances the model state.
	function automatic result_t decide_field(input item_t f);
		result_t     r;
		int unsigned diff, comb, need, limit, rot;
		logic [2:0]  nf;
		r    = '0;
		diff = f.field_diff;
		comb = f.comb_factor;
		if (f.restart) begin
			miss_run   = 0;
			verify_run = 0;
			seen_phase = CODE_NONE;
			prev_comb  = 0;
			clear_switch_log();
		end else begin
			// weave expectation of the mode held before this field
			if (cur_mode >= MODE_FILM0 && cur_mode <= MODE_FILM4 &&
			    f.cadence_pos < CYCLE_LEN) begin
				rot = (int'(f.cadence_pos) + CYCLE_LEN + 1 - int'(cur_mode)) % CYCLE_LEN;
				if (rot == 0)
					r.expect_weave = 1'b0;
				else if (rot <= 2)
					r.expect_weave = !f.is_odd;
				else
					r.expect_weave = f.is_odd;
			end
			if (diff > det_cfg.diff_threshold) begin
				if (film_like(cur_mode)) begin
					limit = (det_cfg.fallback_to_video ? det_cfg.repeat_out
					                                   : det_cfg.repeat_in) * 5;
					if (miss_run > limit) begin
						cur_mode   = MODE_VIDEO;
						r.fell_to_video = 1'b1;
						verify_run = 0;
					end else begin
						// weave would show comb artifacts
						if (det_cfg.mismatch_threshold != 0 &&
						    diff >= det_cfg.mismatch_threshold && r.expect_weave &&
						    comb > prev_comb + det_cfg.comb_threshold &&
						    comb > det_cfg.comb_threshold) begin
							if (det_cfg.fallback_to_video) begin
								cur_mode    = MODE_VIDEO;
								r.fell_to_video = 1'b1;
								hold_repeat = 1;
								verify_run  = 0;
							end else begin
								cur_mode    = MODE_COMB;
								r.entered_comb = 1'b1;
								verify_run  = det_cfg.repeat_in;
								hold_repeat = 0;
								seen_phase  = MODE_COMB;
							end
						end
						if (miss_run < 255)
							miss_run++;
					end
				end else if (miss_run < 255) begin
					miss_run++;
				end
			end else begin
				if (miss_run == 4) begin
					// film phase implied by a match at this position
					if (f.cadence_pos >= CYCLE_LEN)
						nf = MODE_FILM0;
					else
						nf = 3'((int'(f.cadence_pos) + (f.is_odd ? 2 : 4)) % CYCLE_LEN + 1);
					if (nf == seen_phase || (film_like(cur_mode) && seen_phase == MODE_COMB) ||
					    seen_phase == CODE_NONE) begin
						need = (hold_repeat > 0) ? hold_repeat : det_cfg.repeat_in;
						if (verify_run >= need) begin
							hold_repeat = 0;
							cur_mode    = nf;
							if (locked_mode != cur_mode && log_switch(f.time_ms)) begin
								r.rapid_cycling = 1'b1;
								if (det_cfg.fallback_to_video) begin
									cur_mode    = MODE_VIDEO;
									r.fell_to_video = 1'b1;
									verify_run  = 0;
									hold_repeat = det_cfg.repeat_in * 2;
								end
							end
							locked_mode = cur_mode;
						end else if (verify_run < 31) begin
							verify_run++;
						end
						seen_phase = nf;
					end else if (det_cfg.fallback_to_video && !film_like(cur_mode)) begin
						verify_run = 1;
						seen_phase = nf;
					end else begin
						cur_mode = nf;
						if (log_switch(f.time_ms)) begin
							r.rapid_cycling = 1'b1;
							cur_mode    = MODE_VIDEO;
							r.fell_to_video = 1'b1;
							verify_run  = 0;
							hold_repeat = det_cfg.repeat_in * 2;
						end
						if (!det_cfg.fallback_to_video)
							seen_phase = nf;
					end
				end else if (hold_repeat > 0) begin
					verify_run = 0;
				end
				miss_run = 0;
			end
			if (comb > 0)
				prev_comb = comb;
		end
		r.mode = cur_mode;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Field generation
	// ------------------------------------------------------------------
	function automatic item_t make_item(input int unsigned diff, input int unsigned comb,
	                                    input bit odd, input int unsigned pos,
	                                    input logic [31:0] stamp, input bit rst);
		item_t it;
		it.field_diff  = 24'(diff);
		it.comb_factor = 24'(comb);
		it.is_odd      = odd;
		it.cadence_pos = 3'(pos);
		it.time_ms     = stamp;
		it.restart     = rst;
		return it;
	endfunction

	// Queue a field stamped a little after the previous one, with rare jumps.
	task automatic plan_field(input int unsigned diff, input int unsigned comb,
	                          input int unsigned pos, input bit odd, input bit rst);
		if ($urandom_range(0, 49) == 0)
			gen_stamp = $urandom();
		else
			gen_stamp = gen_stamp + $urandom_range(15, 25);
		field_q.push_back(make_item(diff, comb, odd, pos, gen_stamp, rst));
		planned++;
	endtask

	function automatic int unsigned miss_diff();
		int unsigned thr;
		thr = det_cfg.diff_threshold;
		case ($urandom_range(0, 3))
			0:       return thr + 1 + $urandom_range(0, 40);
			1:       return $urandom_range(thr + 1, 24'hFF_FFFF);
			2:       return $urandom_range(thr + 1, thr + 20000);
			default: return thr + 1 + $urandom_range(0, 3000);
		endcase
	endfunction

	function automatic int unsigned match_diff();
		return $urandom_range(0, det_cfg.diff_threshold);
	endfunction

	// Ordinary comb values stay at or under the threshold; a spike clears it well.
	function automatic int unsigned field_comb(input bit spike);
		int unsigned thr;
		thr = det_cfg.comb_threshold;
		if (spike)
			return $urandom_range(3 * thr + 1, 24'hFF_FFFF);
		if ($urandom_range(0, 9) == 0)
			return 0;
		return $urandom_range(1, thr);
	endfunction

	// Mostly well-formed 3:2 cadence runs, plus noise, restarts and broken runs.
	task automatic plan_random(input int unsigned count, input bit long_run);
		int unsigned goal, seg, nmis, ph_pos;
		bit          ph_odd;
		goal   = planned + count;
		ph_pos = $urandom_range(0, 4);
		ph_odd = $urandom_range(0, 1);
		// long mismatch stretch drives the mismatch counter into saturation
		if (long_run)
			repeat ($urandom_range(256, 270))
				plan_field(miss_diff(), field_comb(0), $urandom_range(0, 4),
				           $urandom_range(0, 1), 1'b0);
		while (planned < goal) begin
			seg = $urandom_range(0, 99);
			if (seg < 72) begin
				if ($urandom_range(0, 2) == 0) begin
					ph_pos = $urandom_range(0, 4);
					ph_odd = $urandom_range(0, 1);
				end
				repeat ($urandom_range(1, 8)) begin
					nmis = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 7) : 4;
					for (int i = 0; i < nmis; i++)
						plan_field(miss_diff(), field_comb($urandom_range(0, 15) == 0),
						           (ph_pos + 1 + i) % CYCLE_LEN,
						           (i % 2 == 0) ? !ph_odd : ph_odd, 1'b0);
					plan_field(match_diff(), field_comb(0), ph_pos, ph_odd, 1'b0);
				end
			end else if (seg < 92) begin
				repeat ($urandom_range(1, 6))
					plan_field($urandom_range(0, 1) ? $urandom_range(0, 24'hFF_FFFF)
					                                : match_diff(),
					           $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 7),
					           $urandom_range(0, 1), 1'b0);
			end else begin
				plan_field($urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
				           $urandom_range(0, 7), $urandom_range(0, 1), 1'b1);
			end
		end
	endtask

	// Wait until every planned field was taken and has its result, then let the
	// pipe empty.
	task automatic settle();
		do
			@(posedge clk);
		while (fields_taken < planned || decision_q.size() > 0);
		repeat (6) @(posedge clk);
	endtask

	// Write one register and mirror it into the shadow; the block is idle here.
	task automatic write_reg(input logic [2:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DW'(val);
		case (idx)
			CFG_DIFF_THR:     det_cfg.diff_threshold     = 13'(val);
			CFG_MISMATCH_THR: det_cfg.mismatch_threshold = 14'(val);
			CFG_COMB_THR:     det_cfg.comb_threshold     = 13'(val);
			CFG_FALLBACK:     det_cfg.fallback_to_video  = 1'(val);
			CFG_REPEAT_IN:    det_cfg.repeat_in          = 4'(val);
			CFG_REPEAT_OUT:   det_cfg.repeat_out         = 4'(val);
			CFG_SWITCH_MAX:   det_cfg.switch_max         = 7'(val);
			CFG_SWITCH_IVL:   det_cfg.switch_interval_ms = 14'(val);
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int unsigned d_thr, input int unsigned m_thr,
	                             input int unsigned c_thr, input int unsigned fb,
	                             input int unsigned r_in, input int unsigned r_out,
	                             input int unsigned s_max, input int unsigned s_ivl);
		write_reg(CFG_DIFF_THR, d_thr);
		write_reg(CFG_MISMATCH_THR, m_thr);
		write_reg(CFG_COMB_THR, c_thr);
		write_reg(CFG_FALLBACK, fb);
		write_reg(CFG_REPEAT_IN, r_in);
		write_reg(CFG_REPEAT_OUT, r_out);
		write_reg(CFG_SWITCH_MAX, s_max);
		write_reg(CFG_SWITCH_IVL, s_ivl);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic compare_field(input string name, input int unsigned want_v,
	                             input int unsigned got_v);
		if (want_v != got_v) begin
			fail_count++;
			if (reported < MAX_REPORTS)
				$error("%s: expected %0d, actual %0d (result %0d)", name, want_v, got_v,
				       results_seen);
			reported++;
		end
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Field driver: present queued requests, predict each accepted one
	// ------------------------------------------------------------------
	item_t       tx_item = '0;
	int unsigned send_gap = 0;
	bit          send_calm = 1'b0;

	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = decide_field(tx_item);
				decision_q.push_back(want);
				fields_taken++;
				if (tx_item.restart)
					n_restart++;
				if (want.mode >= MODE_FILM0 && want.mode <= MODE_FILM4)
					n_film++;
				n_fell  += want.fell_to_video;
				n_comb  += want.entered_comb;
				n_rapid += want.rapid_cycling;
				// draw the gap before the next request; flip calm stretches now and then
				send_gap = send_calm ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 99) == 0)
					send_calm = !send_calm;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (field_q.size() > 0) begin
					tx_item = field_q.pop_front();
					s_axis_tdata  <= {4'b0, tx_item.time_ms, tx_item.cadence_pos,
					                  tx_item.is_odd, tx_item.comb_factor, tx_item.field_diff};
					s_axis_tuser  <= tx_item.restart;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: check each result, stall at random, one long hold
	// ------------------------------------------------------------------
	int unsigned recv_wait = 0;
	int unsigned hold_left = 0;
	bit          recv_calm = 1'b0;

	always @(posedge clk) begin
		result_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.mode          = m_axis_tdata[2:0];
				got.fell_to_video = m_axis_tdata[3];
				got.entered_comb  = m_axis_tdata[4];
				got.rapid_cycling = m_axis_tdata[5];
				got.expect_weave  = m_axis_tdata[6];
				if (decision_q.size() == 0) begin
					fail_count++;
					$error("result with no decision pending: tdata 0x%02h", m_axis_tdata);
				end else begin
					want = decision_q.pop_front();
					compare_field("mode", want.mode, got.mode);
					compare_field("fell_to_video", want.fell_to_video, got.fell_to_video);
					compare_field("entered_comb", want.entered_comb, got.entered_comb);
					compare_field("rapid_cycling", want.rapid_cycling, got.rapid_cycling);
					compare_field("expect_weave", want.expect_weave, got.expect_weave);
				end
				recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 99) == 0)
					recv_calm = !recv_calm;
				// back up the detector once while the driver keeps offering
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: count cycles with work outstanding but no request moving
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    !(field_q.size() > 0 || s_axis_tvalid || decision_q.size() > 0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("no request moved for %0d cycles, %0d results still due",
		         stall_cycles, decision_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed fields, then random phases per setting
	// ------------------------------------------------------------------
	initial begin
		clear_switch_log();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, threshold edges, out-of-range positions, restarts
		field_q.push_back(make_item(24'hFF_FFFF, 24'hFF_FFFF, 1, 7, 32'hFFFF_FFFF, 1));
		field_q.push_back(make_item(0, 0, 0, 0, 32'h0, 0));
		field_q.push_back(make_item(24'hFF_FFFF, 24'hFF_FFFF, 1, 7, 32'hFFFF_FFFF, 0));
		field_q.push_back(make_item(15, 300, 0, 5, 32'h10, 0));     // diff at threshold
		field_q.push_back(make_item(16, 301, 1, 6, 32'h20, 0));     // just above it
		field_q.push_back(make_item(100, 0, 0, 7, 32'h30, 0));
		field_q.push_back(make_item(99, 1, 1, 5, 32'h40, 0));
		field_q.push_back(make_item(24'h80_0000, 24'h1, 0, 3, 32'h50, 0));
		field_q.push_back(make_item(0, 5, 1, 6, 32'h60, 0));        // match, phase from bad pos
		field_q.push_back(make_item(5000, 300, 1, 3, 32'h70, 0));
		field_q.push_back(make_item(5000, 301, 0, 4, 32'h80, 0));
		field_q.push_back(make_item(16, 24'hFF_FFFF, 1, 0, 32'h90, 0));
		field_q.push_back(make_item(17, 0, 0, 1, 32'hA0, 0));
		field_q.push_back(make_item(1, 10, 0, 2, 32'hB0, 0));       // match, other phase
		field_q.push_back(make_item(0, 0, 0, 0, 32'h0, 1));         // restart, zero fields
		field_q.push_back(make_item(24'h7F_FFFF, 24'h55_5555, 0, 4, 32'h8000_0000, 0));
		field_q.push_back(make_item(24'hAA_AAAA, 24'hAA_AAAA, 1, 2, 32'h5555_5555, 0));
		planned = field_q.size();
		gen_stamp = 32'h0000_1000;

		// reset values
		plan_random(400, 1'b1);
		settle();
		// low extremes: weave check and switch tracking off, comb fallback
		apply_setting(1, 0, 1, 0, 1, 1, 0, 0);
		plan_random(300, 1'b0);
		settle();
		// high extremes
		apply_setting(5000, 10000, 5000, 1, 10, 10, 64, 10000);
		plan_random(300, 1'b0);
		settle();
		// random middle ground in comb fallback
		apply_setting($urandom_range(1, 200), $urandom_range(1, 2000), $urandom_range(1, 500), 0,
		              $urandom_range(1, 5), $urandom_range(1, 10), $urandom_range(1, 6),
		              $urandom_range(1, 10000));
		plan_random(300, 1'b1);
		settle();
		// quick locking with a tight switch count to provoke rapid cycling
		apply_setting(30, 100, 200, 1, 1, 3, 2, 10000);
		plan_random(300, 1'b0);
		settle();
		repeat (10) @(posedge clk);

		$display("covered %0d fields (%0d restarts) over five register settings, %0d results",
		         fields_taken, n_restart, results_seen);
		$display("film decisions %0d, drops to video %0d, comb entries %0d, rapid cycling %0d",
		         n_film, n_fell, n_comb, n_rapid);
		if (fail_count == 0 && decision_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
